// ===== sv/btag_pkg.sv =====
// Shared types and constants for the blocked transpose address generator.
// Holds register layout, reset values and the walk control group; no dependencies.
`default_nettype none

package btag_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_ADDR_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTER_COUNT = 3'd0,
    REG_ROW_COUNT   = 3'd1,
    REG_COL_COUNT   = 3'd2,
    REG_RUN_LENGTH  = 3'd3,
    REG_TILE_SIZE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] outer_count;
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] col_count;
    logic [CFG_W-1:0] run_length;
    logic [CFG_W-1:0] tile_size;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    outer_count: 13'd320,
    row_count:   13'd100,
    col_count:   13'd8,
    run_length:  13'd64,
    tile_size:   13'd5
  };

  // step: advance after emitting; restart: emit from the first pair; home: rewind
  typedef struct packed {
    logic step;
    logic restart;
    logic home;
  } walk_ctl_t;

endpackage

`default_nettype wire

// ===== sv/btag_prep.sv =====
// Effective sizes and address strides derived from the size registers.
// Uses btag_pkg; products are formed over two registered steps after a start.
`default_nettype none

module btag_prep #(
  parameter int ADDR_BITS = 32,
  parameter int DIM_BITS  = 12
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire btag_pkg::cfg_regs_t    cfg,
  output logic [DIM_BITS:0]           eff_outer,
  output logic [DIM_BITS:0]           eff_row,
  output logic [DIM_BITS:0]           eff_col,
  output logic [DIM_BITS:0]           eff_run,
  output logic [DIM_BITS:0]           eff_tile,
  output logic [ADDR_BITS-1:0]        stride_rl,
  output logic [ADDR_BITS-1:0]        stride_cl,
  output logic [ADDR_BITS-1:0]        stride_tl,
  output logic [ADDR_BITS-1:0]        stride_trl,
  output logic [ADDR_BITS-1:0]        stride_tcl,
  output logic [ADDR_BITS-1:0]        stride_vol,
  output logic                        busy
);
  import btag_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int EW = DIM_BITS + 1;
  localparam int XW = (EW > CFG_W) ? EW : CFG_W;

  typedef enum logic [1:0] {
    PREP_IDLE,
    PREP_PROD,
    PREP_SCALE
  } prep_state_t;

  prep_state_t   state_r;
  logic [AW-1:0] rl_r, cl_r, tl_r, trl_r, tcl_r, vol_r;

  // zero reads as one, anything past 2^DIM_BITS saturates
  function automatic logic [EW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [XW-1:0] vx;
    logic [XW-1:0] lim;
    vx  = XW'(v);
    lim = XW'(1) << DIM_BITS;
    if (vx == '0) begin
      vx = XW'(1);
    end else if (vx > lim) begin
      vx = lim;
    end
    return vx[EW-1:0];
  endfunction

  assign eff_outer = clamp_dim(cfg.outer_count);
  assign eff_row   = clamp_dim(cfg.row_count);
  assign eff_col   = clamp_dim(cfg.col_count);
  assign eff_run   = clamp_dim(cfg.run_length);
  assign eff_tile  = clamp_dim(cfg.tile_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PREP_PROD;
    end else if (start) begin
      state_r <= PREP_PROD;
    end else begin
      case (state_r)
        PREP_PROD: begin
          rl_r    <= AW'(eff_row) * AW'(eff_run);
          cl_r    <= AW'(eff_col) * AW'(eff_run);
          tl_r    <= AW'(eff_tile) * AW'(eff_run);
          state_r <= PREP_SCALE;
        end
        PREP_SCALE: begin
          trl_r   <= AW'(eff_tile) * rl_r;
          tcl_r   <= AW'(eff_tile) * cl_r;
          vol_r   <= AW'(eff_row) * cl_r;
          state_r <= PREP_IDLE;
        end
        default: begin
          state_r <= PREP_IDLE;
        end
      endcase
    end
  end

  assign stride_rl  = rl_r;
  assign stride_cl  = cl_r;
  assign stride_tl  = tl_r;
  assign stride_trl = trl_r;
  assign stride_tcl = tcl_r;
  assign stride_vol = vol_r;
  assign busy       = (state_r != PREP_IDLE);

endmodule

`default_nettype wire

// ===== sv/btag_walk.sv =====
// Loop counters and running address bases of the tiled walk.
// Uses btag_pkg for the control group; strides come from btag_prep.
`default_nettype none

module btag_walk #(
  parameter int ADDR_BITS = 32,
  parameter int DIM_BITS  = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire btag_pkg::walk_ctl_t   ctl,
  input  wire logic [DIM_BITS:0]     eff_outer,
  input  wire logic [DIM_BITS:0]     eff_row,
  input  wire logic [DIM_BITS:0]     eff_col,
  input  wire logic [DIM_BITS:0]     eff_run,
  input  wire logic [DIM_BITS:0]     eff_tile,
  input  wire logic [ADDR_BITS-1:0]  stride_rl,
  input  wire logic [ADDR_BITS-1:0]  stride_cl,
  input  wire logic [ADDR_BITS-1:0]  stride_tl,
  input  wire logic [ADDR_BITS-1:0]  stride_trl,
  input  wire logic [ADDR_BITS-1:0]  stride_tcl,
  input  wire logic [ADDR_BITS-1:0]  stride_vol,
  output logic [ADDR_BITS-1:0]       src_addr,
  output logic [ADDR_BITS-1:0]       dst_addr,
  output logic                       last
);
  import btag_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int DW = DIM_BITS;
  localparam int EW = DIM_BITS + 1;

  logic [DW-1:0] outer_idx_r, row_tile_base_r, col_tile_base_r;
  logic [DW-1:0] row_in_tile_r, col_in_tile_r, elem_in_run_r;
  // base addresses at the start of the outer slice, row tile, tile, row and run
  logic [AW-1:0] outer_base_r;
  logic [AW-1:0] src_rt_r, dst_rt_r, src_tile_r, dst_tile_r;
  logic [AW-1:0] src_row_r, dst_row_r, src_run_r, dst_run_r;

  logic [DW-1:0] outer_idx_c, row_tile_base_c, col_tile_base_c;
  logic [DW-1:0] row_in_tile_c, col_in_tile_c, elem_in_run_c;
  logic [AW-1:0] outer_base_c;
  logic [AW-1:0] src_rt_c, dst_rt_c, src_tile_c, dst_tile_c;
  logic [AW-1:0] src_row_c, dst_row_c, src_run_c, dst_run_c;

  logic [DW-1:0] outer_idx_nxt, row_tile_base_nxt, col_tile_base_nxt;
  logic [DW-1:0] row_in_tile_nxt, col_in_tile_nxt, elem_in_run_nxt;
  logic [AW-1:0] outer_base_nxt;
  logic [AW-1:0] src_rt_nxt, dst_rt_nxt, src_tile_nxt, dst_tile_nxt;
  logic [AW-1:0] src_row_nxt, dst_row_nxt, src_run_nxt, dst_run_nxt;

  logic [EW-1:0] elem_p1, ci_p1, ri_p1, c_p1, r_p1, cb_nt, rb_nt, o_p1;
  logic [AW-1:0] stride_l;

  // restart rewinds the position before this pair is emitted
  always_comb begin
    if (ctl.restart) begin
      outer_idx_c     = '0;
      row_tile_base_c = '0;
      col_tile_base_c = '0;
      row_in_tile_c   = '0;
      col_in_tile_c   = '0;
      elem_in_run_c   = '0;
      outer_base_c    = '0;
      src_rt_c        = '0;
      dst_rt_c        = '0;
      src_tile_c      = '0;
      dst_tile_c      = '0;
      src_row_c       = '0;
      dst_row_c       = '0;
      src_run_c       = '0;
      dst_run_c       = '0;
    end else begin
      outer_idx_c     = outer_idx_r;
      row_tile_base_c = row_tile_base_r;
      col_tile_base_c = col_tile_base_r;
      row_in_tile_c   = row_in_tile_r;
      col_in_tile_c   = col_in_tile_r;
      elem_in_run_c   = elem_in_run_r;
      outer_base_c    = outer_base_r;
      src_rt_c        = src_rt_r;
      dst_rt_c        = dst_rt_r;
      src_tile_c      = src_tile_r;
      dst_tile_c      = dst_tile_r;
      src_row_c       = src_row_r;
      dst_row_c       = dst_row_r;
      src_run_c       = src_run_r;
      dst_run_c       = dst_run_r;
    end
  end

  assign stride_l = AW'(eff_run);
  assign src_addr = src_run_c + AW'(elem_in_run_c);
  assign dst_addr = dst_run_c + AW'(elem_in_run_c);

  assign elem_p1 = EW'(elem_in_run_c) + EW'(1);
  assign ci_p1   = EW'(col_in_tile_c) + EW'(1);
  assign ri_p1   = EW'(row_in_tile_c) + EW'(1);
  assign c_p1    = EW'(col_tile_base_c) + ci_p1;
  assign r_p1    = EW'(row_tile_base_c) + ri_p1;
  assign cb_nt   = EW'(col_tile_base_c) + eff_tile;
  assign rb_nt   = EW'(row_tile_base_c) + eff_tile;
  assign o_p1    = EW'(outer_idx_c) + EW'(1);

  always_comb begin
    outer_idx_nxt     = outer_idx_c;
    row_tile_base_nxt = row_tile_base_c;
    col_tile_base_nxt = col_tile_base_c;
    row_in_tile_nxt   = row_in_tile_c;
    col_in_tile_nxt   = col_in_tile_c;
    elem_in_run_nxt   = elem_in_run_c;
    outer_base_nxt    = outer_base_c;
    src_rt_nxt        = src_rt_c;
    dst_rt_nxt        = dst_rt_c;
    src_tile_nxt      = src_tile_c;
    dst_tile_nxt      = dst_tile_c;
    src_row_nxt       = src_row_c;
    dst_row_nxt       = dst_row_c;
    src_run_nxt       = src_run_c;
    dst_run_nxt       = dst_run_c;
    last              = 1'b0;

    if (elem_p1 < eff_run) begin
      elem_in_run_nxt = elem_p1[DW-1:0];
    end else begin
      elem_in_run_nxt = '0;
      // edge tiles clip where the column or row index runs out
      if (ci_p1 < eff_tile && c_p1 < eff_col) begin
        col_in_tile_nxt = ci_p1[DW-1:0];
        src_run_nxt     = src_run_c + stride_l;
        dst_run_nxt     = dst_run_c + stride_rl;
      end else begin
        col_in_tile_nxt = '0;
        if (ri_p1 < eff_tile && r_p1 < eff_row) begin
          row_in_tile_nxt = ri_p1[DW-1:0];
          src_row_nxt     = src_row_c + stride_cl;
          dst_row_nxt     = dst_row_c + stride_l;
          src_run_nxt     = src_row_nxt;
          dst_run_nxt     = dst_row_nxt;
        end else begin
          row_in_tile_nxt = '0;
          if (cb_nt < eff_col) begin
            col_tile_base_nxt = cb_nt[DW-1:0];
            src_tile_nxt      = src_tile_c + stride_tl;
            dst_tile_nxt      = dst_tile_c + stride_trl;
            src_row_nxt       = src_tile_nxt;
            dst_row_nxt       = dst_tile_nxt;
            src_run_nxt       = src_tile_nxt;
            dst_run_nxt       = dst_tile_nxt;
          end else begin
            col_tile_base_nxt = '0;
            if (rb_nt < eff_row) begin
              row_tile_base_nxt = rb_nt[DW-1:0];
              src_rt_nxt        = src_rt_c + stride_tcl;
              dst_rt_nxt        = dst_rt_c + stride_tl;
              src_tile_nxt      = src_rt_nxt;
              dst_tile_nxt      = dst_rt_nxt;
              src_row_nxt       = src_rt_nxt;
              dst_row_nxt       = dst_rt_nxt;
              src_run_nxt       = src_rt_nxt;
              dst_run_nxt       = dst_rt_nxt;
            end else begin
              row_tile_base_nxt = '0;
              if (o_p1 < eff_outer) begin
                outer_idx_nxt  = o_p1[DW-1:0];
                outer_base_nxt = outer_base_c + stride_vol;
              end else begin
                // final pair: the walk wraps to the first pair
                outer_idx_nxt  = '0;
                outer_base_nxt = '0;
                last           = 1'b1;
              end
              src_rt_nxt   = outer_base_nxt;
              dst_rt_nxt   = outer_base_nxt;
              src_tile_nxt = outer_base_nxt;
              dst_tile_nxt = outer_base_nxt;
              src_row_nxt  = outer_base_nxt;
              dst_row_nxt  = outer_base_nxt;
              src_run_nxt  = outer_base_nxt;
              dst_run_nxt  = outer_base_nxt;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.home) begin
      outer_idx_r     <= '0;
      row_tile_base_r <= '0;
      col_tile_base_r <= '0;
      row_in_tile_r   <= '0;
      col_in_tile_r   <= '0;
      elem_in_run_r   <= '0;
      outer_base_r    <= '0;
      src_rt_r        <= '0;
      dst_rt_r        <= '0;
      src_tile_r      <= '0;
      dst_tile_r      <= '0;
      src_row_r       <= '0;
      dst_row_r       <= '0;
      src_run_r       <= '0;
      dst_run_r       <= '0;
    end else if (ctl.step) begin
      outer_idx_r     <= outer_idx_nxt;
      row_tile_base_r <= row_tile_base_nxt;
      col_tile_base_r <= col_tile_base_nxt;
      row_in_tile_r   <= row_in_tile_nxt;
      col_in_tile_r   <= col_in_tile_nxt;
      elem_in_run_r   <= elem_in_run_nxt;
      outer_base_r    <= outer_base_nxt;
      src_rt_r        <= src_rt_nxt;
      dst_rt_r        <= dst_rt_nxt;
      src_tile_r      <= src_tile_nxt;
      dst_tile_r      <= dst_tile_nxt;
      src_row_r       <= src_row_nxt;
      dst_row_r       <= dst_row_nxt;
      src_run_r       <= src_run_nxt;
      dst_run_r       <= dst_run_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/blocked_transpose_address_gen_top.sv =====
// Blocked transpose address generator: one source/destination address pair per transfer.
// Results are registered in the output stage; throughput 1 per cycle while in_stall is low.
// The loop counters step incrementally, adding precomputed strides to running bases.
// Reset (rst_n low, synchronous) loads default sizes and rewinds the walk; afterwards,
// and after each size register write, stride setup holds in_stall through its product and scale steps.
// Result register plus one skid slot take one more transfer under out_stall, then in_stall rises.
`default_nettype none

module blocked_transpose_address_gen_top #(
  parameter int ADDR_BITS = 32,
  parameter int DIM_BITS  = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_restart,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [btag_pkg::OUT_ADDR_W-1:0]        out_src_addr,
  output logic [btag_pkg::OUT_ADDR_W-1:0]        out_dst_addr,
  output logic                                   out_last,
  // configuration write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [btag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [btag_pkg::CFG_W-1:0]        cfg_wdata
);
  import btag_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int OW = OUT_ADDR_W;

  typedef struct packed {
    logic [OW-1:0] src_addr;
    logic [OW-1:0] dst_addr;
    logic          last;
  } result_t;

  // size registers
  cfg_regs_t cfg_r;
  logic      cfg_hit;

  // stride setup
  logic [DIM_BITS:0] eff_outer, eff_row, eff_col, eff_run, eff_tile;
  logic [AW-1:0]     stride_rl, stride_cl, stride_tl, stride_trl, stride_tcl, stride_vol;
  logic              prep_busy;

  // walk
  walk_ctl_t     walk_ctl;
  logic [AW-1:0] walk_src, walk_dst;
  logic          walk_last;
  logic          in_xfer;

  // output staging
  logic [AW+OW-1:0] src_wide, dst_wide;
  result_t          new_res;
  result_t          out_res_r, skid_res_r;
  logic             out_valid_r, skid_valid_r;
  logic             out_free;

  // Writes to an index past the register list are dropped and leave the walk alone.
  always_comb begin
    case (cfg_index)
      REG_OUTER_COUNT,
      REG_ROW_COUNT,
      REG_COL_COUNT,
      REG_RUN_LENGTH,
      REG_TILE_SIZE: cfg_hit = cfg_wr_en;
      default:       cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OUTER_COUNT: cfg_r.outer_count <= cfg_wdata;
        REG_ROW_COUNT:   cfg_r.row_count   <= cfg_wdata;
        REG_COL_COUNT:   cfg_r.col_count   <= cfg_wdata;
        REG_RUN_LENGTH:  cfg_r.run_length  <= cfg_wdata;
        REG_TILE_SIZE:   cfg_r.tile_size   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  btag_prep #(
    .ADDR_BITS (ADDR_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cfg_hit),
    .cfg        (cfg_r),
    .eff_outer  (eff_outer),
    .eff_row    (eff_row),
    .eff_col    (eff_col),
    .eff_run    (eff_run),
    .eff_tile   (eff_tile),
    .stride_rl  (stride_rl),
    .stride_cl  (stride_cl),
    .stride_tl  (stride_tl),
    .stride_trl (stride_trl),
    .stride_tcl (stride_tcl),
    .stride_vol (stride_vol),
    .busy       (prep_busy)
  );

  // Input is held off while strides settle or while the skid slot is occupied.
  assign in_stall = prep_busy | skid_valid_r;
  assign in_xfer  = in_valid & ~in_stall;

  assign walk_ctl.step    = in_xfer;
  assign walk_ctl.restart = in_restart;
  assign walk_ctl.home    = cfg_hit;

  btag_walk #(
    .ADDR_BITS (ADDR_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (walk_ctl),
    .eff_outer  (eff_outer),
    .eff_row    (eff_row),
    .eff_col    (eff_col),
    .eff_run    (eff_run),
    .eff_tile   (eff_tile),
    .stride_rl  (stride_rl),
    .stride_cl  (stride_cl),
    .stride_tl  (stride_tl),
    .stride_trl (stride_trl),
    .stride_tcl (stride_tcl),
    .stride_vol (stride_vol),
    .src_addr   (walk_src),
    .dst_addr   (walk_dst),
    .last       (walk_last)
  );

  // Addresses are carried at ADDR_BITS and presented as their low 32 bits.
  assign src_wide         = {{OW{1'b0}}, walk_src};
  assign dst_wide         = {{OW{1'b0}}, walk_dst};
  assign new_res.src_addr = src_wide[OW-1:0];
  assign new_res.dst_addr = dst_wide[OW-1:0];
  assign new_res.last     = walk_last;

  // result register can take a new value when empty or being drained this cycle
  assign out_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : new_res;
    end
    if (!out_free && in_xfer) begin
      skid_res_r <= new_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_src_addr = out_res_r.src_addr;
  assign out_dst_addr = out_res_r.dst_addr;
  assign out_last     = out_res_r.last;

endmodule

`default_nettype wire

// ===== sv/btag_checker.sv =====
// Port-level checks for blocked_transpose_address_gen_top, attached by bind.
// Uses btag_pkg for the register index names.
`default_nettype none

module btag_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [btag_pkg::OUT_ADDR_W-1:0] out_src_addr,
  input wire logic [btag_pkg::OUT_ADDR_W-1:0] out_dst_addr,
  input wire logic                           out_last,
  input wire logic                           cfg_wr_en,
  input wire logic [btag_pkg::CFG_IDX_W-1:0] cfg_index
);
  import btag_pkg::*;

  // stride setup after reset keeps input held off
  a_reset_holds_input: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not held off after reset");

  // a size register write restarts stride setup
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && cfg_index <= REG_TILE_SIZE |=> in_stall)
    else $error("input not held off after size register write");

  // a result only appears after an input transfer
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transfer");

  // a stalled result stays put
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_src_addr)
      && $stable(out_dst_addr) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind blocked_transpose_address_gen_top btag_checker u_btag_checker (.*);

`default_nettype wire
